// File: hw/rtl/jai_pkg.sv
// Package for the joint acceleration integrator: sizes, reset values of the
// configuration registers, register indexes and item codes.
// No dependencies; imported by joint_accel_integrator_with_leg_limit.
`timescale 1ns / 1ps
`default_nettype none

package jai_pkg;

    // Leg store geometry
    localparam int NUM_LEGS       = 4;
    localparam int JOINTS         = 4;
    localparam int JOINT_W        = $clog2(JOINTS);
    localparam int LEG_W          = 2;
    localparam int ADDR_W         = $clog2(NUM_LEGS * JOINTS);

    // Value formats
    localparam int VAL_W          = 16;
    localparam int STEP_FRAC      = 16;
    localparam int STEP_W         = 16;
    localparam int VLIM_W         = 15;
    localparam int ALIM_W         = 17;
    localparam int PROD_W         = VAL_W + STEP_W + 1;
    localparam int DELTA_W        = PROD_W - STEP_FRAC;
    localparam int ACC_W          = VAL_W + 2;
    localparam int SUM_W          = VAL_W + 3;

    // Round to nearest, halves toward +infinity
    localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(1) << (STEP_FRAC - 1);

    // Saturation bounds of the position store
    localparam logic signed [ACC_W-1:0] POS_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] POS_MIN = -ACC_W'(32768);

    // Configuration register reset values
    localparam logic [STEP_W-1:0] STEP_TIME_RST       = STEP_W'(1311);
    localparam logic [VLIM_W-1:0] VELOCITY_LIMIT_RST  = VLIM_W'(4096);
    localparam logic [ALIM_W-1:0] ANGLE_SUM_LIMIT_RST = ALIM_W'(9651);

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_STEP_TIME       = 2'd0,
        CFG_VELOCITY_LIMIT  = 2'd1,
        CFG_ANGLE_SUM_LIMIT = 2'd2
    } cfg_index_t;

    // Item operation codes
    typedef enum logic {
        OP_STEP = 1'b0,
        OP_LOAD = 1'b1
    } op_t;

    // Sequencer states
    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MULA = 7'b0000010,
        ST_VEL  = 7'b0000100,
        ST_MULV = 7'b0001000,
        ST_POS  = 7'b0010000,
        ST_LOAD = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/joint_accel_integrator_with_leg_limit.sv
// Joint acceleration integrator with leg angle-sum check: top level.
// Depends on jai_pkg for sizes, codes and register reset values.
//
// Usage:
// An input item on the s_ side carries one leg's four joint values in
// s_tdata and the operation and leg number in s_tuser. A step item
// integrates each action into a velocity (clamped to +/- velocity_limit)
// and the velocity into a position (saturated to the Q4.12 range); a load
// item writes the four values as positions and zeroes the velocities.
// One result item per input item leaves on the m_ side with the leg's four
// positions and the angle-sum flag.
// One multiplier is shared by all products under a small sequencer: a step
// item runs, per joint, an action product, a velocity update, a velocity
// product and a position update, then a done state; a load item runs a load
// state, then the done state. The block takes one item at a time and is
// ready again as soon as the result sits in the output register.
// When the receiver stalls, the result holds in the output register and a
// following item runs up to its final cycle, where it waits for the slot.
// Reset clears all velocities and positions to zero and loads the register
// defaults; configuration is written through cfg_we, cfg_index, cfg_data.
`timescale 1ns / 1ps
`default_nettype none

module joint_accel_integrator_with_leg_limit
    import jai_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // Configuration write port
    input  wire logic                    cfg_we,
    input  wire logic [1:0]              cfg_index,
    input  wire logic [ALIM_W-1:0]       cfg_data,
    // Input items
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [4*VAL_W-1:0]      s_tdata,  // value_joint0..value_joint3
    input  wire logic [LEG_W:0]          s_tuser,  // op, leg
    // Result items
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [4*VAL_W-1:0]           m_tdata,  // position_joint0..position_joint3
    output logic [LEG_W:0]               m_tuser   // leg_out, within_limit
);

    // Configuration registers
    logic [STEP_W-1:0]          step_time_reg;
    logic [VLIM_W-1:0]          velocity_limit_reg;
    logic [ALIM_W-1:0]          angle_sum_limit_reg;

    // Sequencer
    state_t                     state_reg, state_next;
    logic [JOINT_W-1:0]         jcnt_reg;
    logic                       op_reg;
    logic                       leg_ok_reg;
    logic [LEG_W-1:0]           leg_reg;

    // Working data
    logic signed [VAL_W-1:0]    act_reg [JOINTS];
    logic signed [VAL_W-1:0]    pj_reg [JOINTS];
    logic signed [VAL_W-1:0]    vel_reg;
    logic signed [PROD_W-1:0]   prod_reg;

    // Leg state store
    logic signed [VAL_W-1:0]    joint_velocity_reg [NUM_LEGS*JOINTS];
    logic signed [VAL_W-1:0]    joint_position_reg [NUM_LEGS*JOINTS];

    // Output register
    logic                       out_valid_reg;
    logic [LEG_W-1:0]           out_leg_reg;
    logic                       out_within_reg;
    logic signed [VAL_W-1:0]    out_pos_reg [JOINTS];

    logic                       in_accept;
    logic                       in_leg_ok;
    logic                       out_free;
    logic [ADDR_W-1:0]          addr;
    logic signed [VAL_W-1:0]    mul_a;
    logic signed [PROD_W-1:0]   prod;
    logic signed [PROD_W-1:0]   rnd_full;
    logic signed [DELTA_W-1:0]  delta;
    logic signed [ACC_W-1:0]    vlim;
    logic signed [ACC_W-1:0]    vsum;
    logic signed [ACC_W-1:0]    vclamp;
    logic signed [ACC_W-1:0]    psum;
    logic signed [ACC_W-1:0]    psat;
    logic signed [SUM_W-1:0]    angle_sum;
    logic signed [SUM_W-1:0]    alim;
    logic                       sum_in_limit;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign in_leg_ok = (32'(s_tuser[LEG_W:1]) < NUM_LEGS);
    assign out_free  = !out_valid_reg || m_tready;
    assign addr      = ADDR_W'({leg_reg, jcnt_reg});

    // Shared multiplier: action in the first phase, new velocity in the third
    assign mul_a = (state_reg == ST_MULV) ? vel_reg : act_reg[jcnt_reg];
    assign prod  = PROD_W'(mul_a) * PROD_W'($signed({1'b0, step_time_reg}));

    // Round the registered product back to Q4.12
    assign rnd_full = (prod_reg + ROUND_BIAS) >>> STEP_FRAC;
    assign delta    = rnd_full[DELTA_W-1:0];

    // Velocity update with symmetric clamp
    assign vlim = $signed({3'b000, velocity_limit_reg});
    assign vsum = ACC_W'(joint_velocity_reg[addr]) + ACC_W'(delta);
    always_comb
    begin
        if (vsum < -vlim)
        begin
            vclamp = -vlim;
        end
        else if (vsum > vlim)
        begin
            vclamp = vlim;
        end
        else
        begin
            vclamp = vsum;
        end
    end

    // Position update with saturation to the Q4.12 range
    assign psum = ACC_W'(joint_position_reg[addr]) + ACC_W'(delta);
    always_comb
    begin
        if (psum > POS_MAX)
        begin
            psat = POS_MAX;
        end
        else if (psum < POS_MIN)
        begin
            psat = POS_MIN;
        end
        else
        begin
            psat = psum;
        end
    end

    // Strict angle-sum check over joints 1 to 3
    assign angle_sum    = SUM_W'(pj_reg[1]) + SUM_W'(pj_reg[2]) + SUM_W'(pj_reg[3]);
    assign alim         = $signed({2'b00, angle_sum_limit_reg});
    assign sum_in_limit = leg_ok_reg && (angle_sum < alim) && (angle_sum > -alim);

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (!in_leg_ok)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (s_tuser[0] == OP_LOAD)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_MULA;
                    end
                end
            end
            ST_MULA: state_next = ST_VEL;
            ST_VEL:  state_next = ST_MULV;
            ST_MULV: state_next = ST_POS;
            ST_POS:
            begin
                state_next = (jcnt_reg == JOINT_W'(JOINTS - 1)) ? ST_DONE : ST_MULA;
            end
            ST_LOAD: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= ST_IDLE;
            jcnt_reg            <= '0;
            out_valid_reg       <= 1'b0;
            step_time_reg       <= STEP_TIME_RST;
            velocity_limit_reg  <= VELOCITY_LIMIT_RST;
            angle_sum_limit_reg <= ANGLE_SUM_LIMIT_RST;
        end
        else
        begin
            state_reg <= state_next;

            // Advance the joint counter after each position update
            if (in_accept)
            begin
                jcnt_reg <= '0;
            end
            else if (state_reg == ST_POS)
            begin
                jcnt_reg <= jcnt_reg + JOINT_W'(1);
            end

            // Hold the result until taken
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_STEP_TIME:       step_time_reg       <= cfg_data[STEP_W-1:0];
                    CFG_VELOCITY_LIMIT:  velocity_limit_reg  <= cfg_data[VLIM_W-1:0];
                    CFG_ANGLE_SUM_LIMIT: angle_sum_limit_reg <= cfg_data;
                    default:             ;
                endcase
            end
        end
    end

    // Leg state store, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEGS * JOINTS; i++)
            begin
                joint_velocity_reg[i] <= '0;
                joint_position_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                ST_VEL:
                begin
                    joint_velocity_reg[addr] <= vclamp[VAL_W-1:0];
                end
                ST_POS:
                begin
                    joint_position_reg[addr] <= psat[VAL_W-1:0];
                end
                ST_LOAD:
                begin
                    for (int j = 0; j < JOINTS; j++)
                    begin
                        joint_position_reg[ADDR_W'({leg_reg, JOINT_W'(j)})] <= act_reg[j];
                        joint_velocity_reg[ADDR_W'({leg_reg, JOINT_W'(j)})] <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Working data path
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg     <= s_tuser[0];
            leg_reg    <= s_tuser[LEG_W:1];
            leg_ok_reg <= in_leg_ok;
            for (int j = 0; j < JOINTS; j++)
            begin
                act_reg[j] <= s_tdata[j*VAL_W +: VAL_W];
                pj_reg[j]  <= '0;
            end
        end
        else
        begin
            case (state_reg)
                ST_MULA, ST_MULV:
                begin
                    prod_reg <= prod;
                end
                ST_VEL:
                begin
                    vel_reg <= vclamp[VAL_W-1:0];
                end
                ST_POS:
                begin
                    pj_reg[jcnt_reg] <= psat[VAL_W-1:0];
                end
                ST_LOAD:
                begin
                    for (int j = 0; j < JOINTS; j++)
                    begin
                        pj_reg[j] <= act_reg[j];
                    end
                end
                default: ;
            endcase
        end
    end

    // Output register load
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
        begin
            out_leg_reg    <= leg_reg;
            out_within_reg <= sum_in_limit;
            for (int j = 0; j < JOINTS; j++)
            begin
                out_pos_reg[j] <= pj_reg[j];
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_within_reg, out_leg_reg};
    always_comb
    begin
        for (int j = 0; j < JOINTS; j++)
        begin
            m_tdata[j*VAL_W +: VAL_W] = out_pos_reg[j];
        end
    end

    // Stored velocity never leaves the clamp window
    a_vel_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_VEL) |-> (vclamp <= vlim) && (vclamp >= -vlim))
        else $error("velocity update outside the clamp window");

    // A valid step item starts on joint 0 with the action product
    a_step_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_leg_ok && s_tuser[0] == OP_STEP)
        |=> (state_reg == ST_MULA) && (jcnt_reg == '0) && (op_reg == OP_STEP))
        else $error("step item did not start on joint 0");

    // A finished item reaches the output register and frees the input
    a_done_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=> m_tvalid && s_tready)
        else $error("finished item not presented");

    // The sequence leaves the joint loop only after the last joint
    a_loop_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POS && jcnt_reg != JOINT_W'(JOINTS - 1)) |=> (state_reg == ST_MULA))
        else $error("joint loop ended early");

endmodule

`default_nettype wire

// File: tb/sv/joint_accel_integrator_with_leg_limit_tb.sv
// Self-checking testbench for joint_accel_integrator_with_leg_limit: drives step and
// load items, predicts positions and the angle-sum flag per leg, checks every result.
// Depends on jai_pkg and the block's top level only.
`timescale 1ns / 1ps

module joint_accel_integrator_with_leg_limit_tb;
    import jai_pkg::*;

    localparam int          WATCHDOG_LIMIT   = 4000;
    localparam int          SETTLE_CYCLES    = 24;
    localparam int          ITEMS_PER_PHASE  = 200;
    localparam int          NUM_PHASES       = 8;
    localparam logic [1:0]  CFG_UNUSED_INDEX = 2'd3;

    typedef struct packed {
        op_t                  op;
        logic [LEG_W-1:0]     leg;
        logic [4*VAL_W-1:0]   values;
    } leg_item_t;

    typedef struct packed {
        logic [LEG_W-1:0]     leg;
        logic [4*VAL_W-1:0]   positions;
        logic                 in_limit;
    } leg_result_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [1:0]           cfg_index = '0;
    logic [ALIM_W-1:0]    cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [4*VAL_W-1:0]   s_tdata   = '0;  // value_joint0..value_joint3
    logic [LEG_W:0]       s_tuser   = '0;  // op, leg
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [4*VAL_W-1:0]   m_tdata;         // position_joint0..position_joint3
    logic [LEG_W:0]       m_tuser;         // leg_out, within_limit

    joint_accel_integrator_with_leg_limit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Shadow registers and per-joint state of the predictor
    longint step_time_q  = 1311;
    int     vel_limit_q  = 4096;
    int     sum_limit_q  = 9651;
    int     leg_velocity [NUM_LEGS*JOINTS];
    int     leg_position [NUM_LEGS*JOINTS];

    leg_item_t   pending_items [$];
    leg_result_t expected_positions [$];
    leg_item_t   item_on_bus;

    int send_idle_pct   = 21;
    int recv_idle_pct   = 83;
    int queued_count    = 0;
    int accepted_count  = 0;
    int results_checked = 0;
    int err_count       = 0;
    int idle_cycles     = 0;

    // Clamp to the signed 16-bit range
    function automatic int sat_q412(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Scale by step_time (Q0.16), rounding halves toward +infinity
    function automatic int scale_by_step(input longint x);
        return int'((x * step_time_q + 64'sd32768) >>> STEP_FRAC);
    endfunction

    // Advance one leg's joints and return the positions and angle-sum flag
    function automatic leg_result_t integrate_leg(input leg_item_t it);
        leg_result_t r;
        int          base;
        int          a;
        int          v;
        int          sum;
        int          pos [JOINTS];
        r     = '0;
        r.leg = it.leg;
        if (int'(it.leg) < NUM_LEGS)
        begin
            base = int'(it.leg) * JOINTS;
            for (int j = 0; j < JOINTS; j++)
            begin
                a = int'($signed(it.values[j*VAL_W +: VAL_W]));
                if (it.op == OP_LOAD)
                begin
                    leg_position[base+j] = a;
                    leg_velocity[base+j] = 0;
                end
                else
                begin
                    v = leg_velocity[base+j] + scale_by_step(longint'(a));
                    if (v < -vel_limit_q)
                        v = -vel_limit_q;
                    else if (v > vel_limit_q)
                        v = vel_limit_q;
                    leg_velocity[base+j] = v;
                    leg_position[base+j] =
                        sat_q412(leg_position[base+j] + scale_by_step(longint'(v)));
                end
                pos[j] = leg_position[base+j];
                r.positions[j*VAL_W +: VAL_W] = VAL_W'(pos[j]);
            end
            sum        = pos[1] + pos[2] + pos[3];
            r.in_limit = (sum < sum_limit_q) && (sum > -sum_limit_q);
        end
        return r;
    endfunction

    // Clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Drive input items; predict each one as it is accepted
    always @(posedge clk or negedge rst_n)
    begin : drive_items
        logic slot_free;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            slot_free = !s_tvalid || s_tready;
            if (s_tvalid && s_tready)
            begin
                expected_positions.push_back(integrate_leg(item_on_bus));
                accepted_count++;
            end
            if (slot_free)
            begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    item_on_bus = pending_items.pop_front();
                    s_tvalid    <= 1'b1;
                    s_tdata     <= item_on_bus.values;
                    s_tuser     <= {item_on_bus.leg, item_on_bus.op};
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Accept results and compare with the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin : check_results
        leg_result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_positions.size() == 0)
                begin
                    $error("result for leg %0d with nothing expected", m_tuser[LEG_W-1:0]);
                    err_count++;
                end
                else
                begin
                    want = expected_positions.pop_front();
                    results_checked++;
                    if (m_tuser[LEG_W-1:0] !== want.leg)
                    begin
                        $error("leg_out: expected %0d, got %0d", want.leg, m_tuser[LEG_W-1:0]);
                        err_count++;
                    end
                    for (int j = 0; j < JOINTS; j++)
                    begin
                        if (m_tdata[j*VAL_W +: VAL_W] !== want.positions[j*VAL_W +: VAL_W])
                        begin
                            $error("position_joint%0d: expected %0d, got %0d", j,
                                   $signed(want.positions[j*VAL_W +: VAL_W]),
                                   $signed(m_tdata[j*VAL_W +: VAL_W]));
                            err_count++;
                        end
                    end
                    if (m_tuser[LEG_W] !== want.in_limit)
                    begin
                        $error("within_limit: expected %0d, got %0d", want.in_limit,
                               m_tuser[LEG_W]);
                        err_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Stop a hung run: count cycles in which nothing moves
    always @(posedge clk)
    begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !rst_n)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $error("no item moved for %0d cycles, %0d results outstanding",
                   WATCHDOG_LIMIT, expected_positions.size());
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic queue_item(input op_t op, input int leg,
                              input int j0, input int j1, input int j2, input int j3);
        leg_item_t it;
        it.op     = op;
        it.leg    = LEG_W'(leg);
        it.values = {VAL_W'(j3), VAL_W'(j2), VAL_W'(j1), VAL_W'(j0)};
        pending_items.push_back(it);
        queued_count++;
    endtask

    // Write one register and mirror it in the shadow copy
    task automatic write_reg(input logic [1:0] idx, input int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= ALIM_W'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_STEP_TIME:       step_time_q = longint'(value & 'hFFFF);
            CFG_VELOCITY_LIMIT:  vel_limit_q = value & 'h7FFF;
            CFG_ANGLE_SUM_LIMIT: sum_limit_q = value & 'h1FFFF;
            default:             ;
        endcase
    endtask

    task automatic set_limits(input int step_time, input int vel_limit, input int sum_limit);
        write_reg(CFG_STEP_TIME, step_time);
        write_reg(CFG_VELOCITY_LIMIT, vel_limit);
        write_reg(CFG_ANGLE_SUM_LIMIT, sum_limit);
    endtask

    // Hold until every queued item has been accepted and answered, then settle
    task automatic wait_drained();
        while (accepted_count != queued_count || expected_positions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic int random_value();
        return int'($signed(VAL_W'($urandom)));
    endfunction

    // Random traffic: mostly bursts of steps on one leg, some loads
    task automatic queue_random_items(input int count);
        int n;
        int leg;
        int kind;
        int len;
        int p1;
        int p2;
        int a [JOINTS];
        n = 0;
        while (n < count)
        begin
            leg  = $urandom_range(0, NUM_LEGS - 1);
            kind = $urandom_range(0, 99);
            if (kind < 10)
            begin
                queue_item(OP_LOAD, leg, random_value(), random_value(),
                           random_value(), random_value());
                n++;
            end
            else if (kind < 16)
            begin
                // land the angle sum on or next to the bound
                p1 = $urandom_range(0, 32767) - 16384;
                p2 = $urandom_range(0, 32767) - 16384;
                a[3] = ($urandom_range(0, 1) ? sum_limit_q : -sum_limit_q)
                       + $urandom_range(0, 2) - 1 - p1 - p2;
                queue_item(OP_LOAD, leg, random_value(), p1, p2, sat_q412(a[3]));
                n++;
            end
            else
            begin
                len  = $urandom_range(1, 12);
                kind = $urandom_range(0, 9);
                for (int k = 0; k < len && n < count; k++)
                begin
                    for (int j = 0; j < JOINTS; j++)
                    begin
                        if (kind < 4)
                            a[j] = random_value();
                        else if (kind < 8)
                            a[j] = $urandom_range(0, 1024) - 512;
                        else
                            a[j] = (kind == 8) ? 32767 : -32768;
                    end
                    queue_item(OP_STEP, leg, a[0], a[1], a[2], a[3]);
                    n++;
                end
            end
        end
    endtask

    // Stimulus and end of run
    initial
    begin
        for (int i = 0; i < NUM_LEGS*JOINTS; i++)
        begin
            leg_velocity[i] = 0;
            leg_position[i] = 0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part at the reset settings
        queue_item(OP_STEP, 0, 0, 0, 0, 0);
        queue_item(OP_STEP, 0, 32767, 32767, 32767, 32767);
        // drive leg 1 into the negative velocity clamp
        for (int k = 0; k < 8; k++)
            queue_item(OP_STEP, 1, -32768, -32768, -32768, -32768);
        queue_item(OP_LOAD, 2, 32767, -32768, 0, 0);
        // angle sum just inside and exactly on both bounds
        queue_item(OP_LOAD, 3, 0, 9650, 0, 0);
        queue_item(OP_LOAD, 3, 0, 9651, 0, 0);
        queue_item(OP_LOAD, 3, 0, -9650, 0, 0);
        queue_item(OP_LOAD, 3, 0, 0, -9651, 0);
        // position saturation at both ends
        queue_item(OP_LOAD, 2, 32767, 32767, 32767, 32767);
        queue_item(OP_STEP, 2, 32767, 32767, 32767, 32767);
        queue_item(OP_LOAD, 3, -32768, -32768, -32768, -32768);
        queue_item(OP_STEP, 3, -32768, -32768, -32768, -32768);
        queue_item(OP_LOAD, 0, -32768, 32767, -1, 1);
        queue_item(OP_STEP, 0, -1, 1, -32768, 32767);
        wait_drained();

        // Random phases, each under its own register settings
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph < 3)
            begin
                send_idle_pct = 21;
                recv_idle_pct = 83;
            end
            else if (ph < 6)
            begin
                send_idle_pct = 83;
                recv_idle_pct = 21;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph)
                0:
                begin
                    set_limits(65535, 32767, 98301);
                    write_reg(CFG_UNUSED_INDEX, $urandom_range(0, 'h1FFFF));
                end
                1:       set_limits(1, 0, 0);
                2:       set_limits(0, 100, 5000);
                3:       set_limits(1311, 4096, 9651);
                4:       set_limits(20000, 1000, 20000);
                6:       set_limits(65535, 32767, 12000);
                default: set_limits($urandom_range(0, 'h1FFFF), $urandom_range(0, 'h1FFFF),
                                    $urandom_range(0, 'h1FFFF));
            endcase
            queue_random_items(ITEMS_PER_PHASE);
            wait_drained();
        end

        $display("Drove %0d step and load items over %0d register settings and three idling modes;",
                 accepted_count, NUM_PHASES + 1);
        $display("%0d results compared field by field, %0d mismatches.",
                 results_checked, err_count);
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: joint_accel_integrator_with_leg_limit.f
hw/rtl/jai_pkg.sv
hw/rtl/joint_accel_integrator_with_leg_limit.sv
tb/sv/joint_accel_integrator_with_leg_limit_tb.sv
